/* hdl/json_string_unescape_utf8_top_defines.svh */
// Assertion macros shared by the checker of the JSON string unescaper.
// No dependencies; the asserting file must provide clk and rst_n.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked around reset.
`define JSU_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/jsu_pkg.sv */
// Package of the JSON string unescaper: item types, phase codes, characters
// and the small decode functions. No dependencies.
package jsu_pkg;

  localparam int LIMIT_MAX = 1024;
  localparam int MAX_RES   = 6;
  localparam int RAW_MAX   = 5;

  localparam logic [2:0] PH_PLAIN = 3'd0;
  localparam logic [2:0] PH_BSL   = 3'd1;
  localparam logic [2:0] PH_U0    = 3'd2;
  localparam logic [2:0] PH_U1    = 3'd3;
  localparam logic [2:0] PH_U2    = 3'd4;
  localparam logic [2:0] PH_U3    = 3'd5;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [10:0] LIMIT_RESET = 11'd64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       run_last;
  } jsu_out_t;

  typedef struct packed {
    logic [2:0]                 cnt;
    jsu_out_t [MAX_RES-1:0]     ent;
  } jsu_grp_t;

  // {hit, mapped byte}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_SLASH: r = {1'b1, CH_SLASH};
      CH_QUOTE: r = {1'b1, CH_QUOTE};
      CH_BSL:   r = {1'b1, CH_BSL};
      CH_N:     r = {1'b1, CH_LF};
      CH_T:     r = {1'b1, CH_TAB};
      CH_R:     r = {1'b1, CH_CR};
      default:  r = 9'h000;
    endcase
    return r;
  endfunction

  // non-hex characters count as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] r;
    if (c inside {[8'h30:8'h39]}) r = 4'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) r = 4'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) r = 4'(c - 8'h37);
    else r = 4'h0;
    return r;
  endfunction

endpackage

/* hdl/jsu_decode.sv */
// Escape decoder of the JSON string unescaper: phase, held digits, code point,
// byte count and limit register; builds one result group per item. Uses jsu_pkg.
module jsu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  jsu_pkg::jsu_in_t  in_data,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata,
  output jsu_pkg::jsu_grp_t grp
);

  localparam int RAW_LAST = jsu_pkg::RAW_MAX - 1;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [10:0] wc_r, wc_nxt;
  logic [10:0] limit_r;
  logic [7:0]  held_r [0:2];

  logic [7:0]  c;
  logic        last;
  logic [1:0]  k;
  logic [3:0]  hx;
  logic [8:0]  esc_c;
  logic [8:0]  esc_t;
  logic [15:0] cp;
  logic [7:0]  tl [0:3];
  logic [2:0]  tl_len;
  logic [2:0]  pos;
  logic [7:0]  raw [0:RAW_LAST];
  logic [2:0]  raw_n;
  logic        atomic;
  logic        held_we;
  logic [10:0] lim, cap, room;
  logic [2:0]  emit_n;

  assign c    = in_data.in_byte;
  assign last = in_data.last_byte;

  always_comb begin
    raw[0] = 8'h00; raw[1] = 8'h00; raw[2] = 8'h00; raw[3] = 8'h00; raw[4] = 8'h00;
    raw_n     = 3'd0;
    atomic    = 1'b0;
    held_we   = 1'b0;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    pos       = 3'd0;
    esc_t     = 9'h000;
    k      = 2'(phase_r - jsu_pkg::PH_U0);
    hx     = jsu_pkg::hex_value(c);
    esc_c  = jsu_pkg::simple_escape(c);
    cp     = {acc_r[11:0], hx};
    tl[0]  = (k == 2'd0) ? c : held_r[0];
    tl[1]  = (k == 2'd1) ? c : held_r[1];
    tl[2]  = c;
    tl[3]  = 8'h00;
    tl_len = {1'b0, k} + 3'd1;

    case (phase_r)
      jsu_pkg::PH_PLAIN: begin
        if (c == jsu_pkg::CH_BSL && !last) begin
          phase_nxt = jsu_pkg::PH_BSL;
        end else begin
          raw[0] = c;
          raw_n  = 3'd1;
        end
      end
      jsu_pkg::PH_BSL: begin
        phase_nxt = jsu_pkg::PH_PLAIN;
        if (esc_c[8]) begin
          raw[0] = esc_c[7:0];
          raw_n  = 3'd1;
        end else if (c == jsu_pkg::CH_U && !last) begin
          acc_nxt   = 16'h0000;
          phase_nxt = jsu_pkg::PH_U0;
        end else begin
          raw[0] = jsu_pkg::CH_BSL;
          raw[1] = c;
          raw_n  = 3'd2;
        end
      end
      jsu_pkg::PH_U0, jsu_pkg::PH_U1, jsu_pkg::PH_U2: begin
        if (last) begin
          // short \u: emit it verbatim, then replay the held tail
          raw[0] = jsu_pkg::CH_BSL;
          raw[1] = jsu_pkg::CH_U;
          raw_n  = 3'd2;
          for (int s = 0; s < 3; s++) begin
            if (pos < tl_len) begin
              esc_t = jsu_pkg::simple_escape(tl[2'(pos + 3'd1)]);
              if (tl[pos[1:0]] == jsu_pkg::CH_BSL && (pos + 3'd1) < tl_len) begin
                if (esc_t[8]) begin
                  raw[raw_n] = esc_t[7:0];
                  pos = pos + 3'd2;
                end else begin
                  raw[raw_n] = jsu_pkg::CH_BSL;
                  pos = pos + 3'd1;
                end
              end else begin
                raw[raw_n] = tl[pos[1:0]];
                pos = pos + 3'd1;
              end
              raw_n = raw_n + 3'd1;
            end
          end
        end else begin
          held_we   = 1'b1;
          acc_nxt   = cp;
          phase_nxt = phase_r + 3'd1;
        end
      end
      jsu_pkg::PH_U3: begin
        atomic    = 1'b1;
        phase_nxt = jsu_pkg::PH_PLAIN;
        if (cp < 16'h0080) begin
          raw[0] = cp[7:0];
          raw_n  = 3'd1;
        end else if (cp < 16'h0800) begin
          raw[0] = 8'hC0 | {3'b000, cp[10:6]};
          raw[1] = 8'h80 | {2'b00, cp[5:0]};
          raw_n  = 3'd2;
        end else begin
          raw[0] = 8'hE0 | {4'h0, cp[15:12]};
          raw[1] = 8'h80 | {2'b00, cp[11:6]};
          raw[2] = 8'h80 | {2'b00, cp[5:0]};
          raw_n  = 3'd3;
        end
      end
      default: begin
        phase_nxt = jsu_pkg::PH_PLAIN;
        raw[0]    = c;
        raw_n     = 3'd1;
      end
    endcase

    if (last) begin
      phase_nxt = jsu_pkg::PH_PLAIN;
      acc_nxt   = 16'h0000;
    end
  end

  // clamp the limit and trim the group to the room left
  always_comb begin
    lim  = (limit_r > 11'(jsu_pkg::LIMIT_MAX)) ? 11'(jsu_pkg::LIMIT_MAX) : limit_r;
    cap  = (lim == 11'd0) ? 11'd0 : lim - 11'd1;
    room = (wc_r >= cap) ? 11'd0 : cap - wc_r;
    if (atomic) begin
      emit_n = ({8'h00, raw_n} <= room) ? raw_n : 3'd0;
    end else begin
      emit_n = ({8'h00, raw_n} <= room) ? raw_n : room[2:0];
    end
    wc_nxt = last ? 11'd0 : wc_r + {8'h00, emit_n};
  end

  always_comb begin
    grp.cnt = emit_n + {2'b00, last};
    for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
      grp.ent[i].out_byte    = (3'(i) < emit_n) ? raw[3'(i < RAW_LAST ? i : RAW_LAST)] : 8'h00;
      grp.ent[i].byte_valid  = (3'(i) < emit_n);
      grp.ent[i].string_done = (3'(i) == emit_n) && last;
      grp.ent[i].run_last    = (3'(i) == grp.cnt - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_PLAIN;
      acc_r   <= 16'h0000;
      wc_r    <= 11'd0;
      limit_r <= jsu_pkg::LIMIT_RESET;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        wc_r    <= wc_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_we) begin
      held_r[k] <= c;
    end
  end

endmodule

/* hdl/jsu_queue.sv */
// Result side of the JSON string unescaper: holds one result group and
// drains it through an output register. Uses jsu_pkg.
module jsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jsu_pkg::jsu_grp_t grp,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output jsu_pkg::jsu_out_t out_data
);

  logic [2:0]                               g_cnt_r;
  logic [2:0]                               g_idx_r;
  jsu_pkg::jsu_out_t [jsu_pkg::MAX_RES-1:0] g_ent_r;
  logic                                     o_valid_r;
  jsu_pkg::jsu_out_t                        o_data_r;

  logic g_has, o_free, move, g_done;

  assign g_has  = (g_cnt_r != 3'd0);
  assign o_free = !o_valid_r || !out_stall;
  assign move   = g_has && o_free;
  assign g_done = move && (g_idx_r == g_cnt_r - 3'd1);

  // hold the input while the group still has entries beyond this cycle
  assign in_stall  = g_has && !g_done;
  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_cnt_r   <= 3'd0;
      g_idx_r   <= 3'd0;
      o_valid_r <= 1'b0;
    end else begin
      if (load) begin
        g_cnt_r <= grp.cnt;
        g_idx_r <= 3'd0;
      end else if (g_done) begin
        g_cnt_r <= 3'd0;
      end else if (move) begin
        g_idx_r <= g_idx_r + 3'd1;
      end
      if (move) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      g_ent_r <= grp.ent;
    end
    if (move) begin
      o_data_r <= g_ent_r[g_idx_r];
    end
  end

endmodule

/* hdl/json_string_unescape_utf8_top.sv */
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_decode and jsu_queue; types come from jsu_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one raw byte of a
//   JSON string body per item; in_data.last_byte marks the final byte.
//   Output channel (out_valid / out_stall / out_data) gives decoded bytes
//   (byte_valid=1) and, after the final byte, one closing marker
//   (byte_valid=0, string_done=1). run_last flags the last result of an item.
//   cfg_we / cfg_wdata write the output limit; write it only while idle.
// Path: each result of an item passes through the group register and then
//   the output register.
// Throughput: one item per cycle while each item yields at most one result
//   and out_stall is low; the single group register drains one entry per
//   cycle into the output register while that is free, so an item with more
//   results (up to six, e.g. a \u escape or short \u tail) holds the input.
// Reset (rst_n low, synchronous): plain-text phase, count cleared, limit 64,
//   both registers empty.
// Stall: a stalled result holds in the output register; the group register
//   still takes one more item, after which in_stall rises.
module json_string_unescape_utf8_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jsu_pkg::jsu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jsu_pkg::jsu_out_t out_data,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata
);

  logic              take;
  logic              load;
  jsu_pkg::jsu_grp_t grp;

  // an item is taken when offered and not held back
  assign take = in_valid && !in_stall;
  // drop empty groups: items swallowed by an escape or the limit
  assign load = take && (grp.cnt != 3'd0);

  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .grp       (grp)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp       (grp),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/jsu_checker.sv */
// Port-level checker of the JSON string unescaper, bound to the top level.
// Uses jsu_pkg and the macros of json_string_unescape_utf8_top_defines.svh.
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input jsu_pkg::jsu_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input jsu_pkg::jsu_out_t out_data
);

  `JSU_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled item changed")
  `JSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `JSU_ASSERT_NOW(a_marker_shape, out_valid && !out_data.byte_valid, out_data.string_done && out_data.run_last && out_data.out_byte == 8'h00, "malformed closing marker")
  `JSU_ASSERT_NOW(a_byte_not_done, out_valid && out_data.byte_valid, !out_data.string_done, "data byte flagged as string end")
  `JSU_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result shown right after reset")

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);

/* tb/json_string_unescape_utf8_top_tb.sv */
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg and json_string_unescape_utf8_top; uses nothing else.
module json_string_unescape_utf8_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  jsu_pkg::jsu_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  jsu_pkg::jsu_out_t out_data;
  logic              cfg_we = 1'b0;
  logic [10:0]       cfg_wdata = '0;

  json_string_unescape_utf8_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Items waiting for the driver, and the bookkeeping that tells when the
  // block has gone quiet.
  jsu_pkg::jsu_in_t  pending_q[$];
  int       queued_count = 0;
  int       accepted_count = 0;
  logic     byte_taken = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       fail_count = 0;

  // Decoder shadow state: the limit register plus the per-string state.
  logic [10:0] limit_reg = jsu_pkg::LIMIT_RESET;
  logic [2:0]  esc_phase = jsu_pkg::PH_PLAIN;
  logic [7:0]  held_chars [3];
  logic [15:0] cp_acc = '0;
  int          emitted = 0;
  jsu_pkg::jsu_out_t item_results[$];   // results of the item being decoded
  jsu_pkg::jsu_out_t decoded_q[$];      // decoded bytes and markers still owed

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------

  // {known escape, byte it stands for}
  function automatic logic [8:0] escape_target(input logic [7:0] c);
    case (c)
      jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL: return {1'b1, c};
      jsu_pkg::CH_N: return {1'b1, jsu_pkg::CH_LF};
      jsu_pkg::CH_T: return {1'b1, jsu_pkg::CH_TAB};
      jsu_pkg::CH_R: return {1'b1, jsu_pkg::CH_CR};
      default: return 9'h000;
    endcase
  endfunction

  // The low nibble of an ASCII digit is its value; letters are off by nine.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return c[3:0] + 4'd9;
    return 4'h0;
  endfunction

  // Bytes a string may carry in total: limit minus one, limit clamped at max.
  function automatic int byte_budget();
    int lim;
    lim = (limit_reg > jsu_pkg::LIMIT_MAX) ? jsu_pkg::LIMIT_MAX : int'(limit_reg);
    return (lim == 0) ? 0 : lim - 1;
  endfunction

  // Emit a character of len bytes, or drop it whole if it does not fit.
  task automatic put_bytes(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input int len);
    jsu_pkg::jsu_out_t r;
    logic [7:0] seq [3];
    if (emitted + len > byte_budget()) return;
    seq = '{b0, b1, b2};
    for (int i = 0; i < len; i++) begin
      r.out_byte    = seq[i];
      r.byte_valid  = 1'b1;
      r.string_done = 1'b0;
      r.run_last    = 1'b0;
      if (item_results.size() < jsu_pkg::MAX_RES) item_results.push_back(r);
    end
    emitted += len;
  endtask

  task automatic put_char(input logic [7:0] c);
    put_bytes(c, 8'h00, 8'h00, 1);
  endtask

  task automatic put_code_point(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      put_char(cp[7:0]);
    end else if (cp < 16'h0800) begin
      put_bytes(8'hC0 | cp[10:6], 8'h80 | cp[5:0], 8'h00, 2);
    end else begin
      put_bytes(8'hE0 | cp[15:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0], 3);
    end
  endtask

  // Decode the bytes of a cut-off \u again: simple escapes apply, a
  // backslash with nothing usable after it stays as it is.
  task automatic replay_tail(input logic [7:0] s [4], input int len);
    int i;
    logic [8:0] m;
    i = 0;
    while (i < len) begin
      if (s[i] == jsu_pkg::CH_BSL && i + 1 < len) begin
        m = escape_target(s[i + 1]);
        if (m[8]) begin
          put_char(m[7:0]);
          i += 2;
        end else begin
          put_char(jsu_pkg::CH_BSL);
          i += 1;
        end
      end else begin
        put_char(s[i]);
        i += 1;
      end
    end
  endtask

  // Advance the shadow state by one accepted item and queue its results.
  task automatic predict_item(input logic [7:0] c, input logic fin);
    logic [8:0] m;
    logic [7:0] tail [4];
    int k;
    jsu_pkg::jsu_out_t r;
    item_results.delete();
    case (esc_phase)
      jsu_pkg::PH_PLAIN: begin
        if (c == jsu_pkg::CH_BSL && !fin) esc_phase = jsu_pkg::PH_BSL;
        else put_char(c);
      end
      jsu_pkg::PH_BSL: begin
        m = escape_target(c);
        if (m[8]) begin
          put_char(m[7:0]);
          esc_phase = jsu_pkg::PH_PLAIN;
        end else if (c == jsu_pkg::CH_U && !fin) begin
          cp_acc = '0;
          esc_phase = jsu_pkg::PH_U0;
        end else begin
          // unknown escape: backslash goes out, the character is plain text
          put_char(jsu_pkg::CH_BSL);
          put_char(c);
          esc_phase = jsu_pkg::PH_PLAIN;
        end
      end
      jsu_pkg::PH_U3: begin
        put_code_point({cp_acc[11:0], hex_nibble(c)});
        esc_phase = jsu_pkg::PH_PLAIN;
      end
      default: begin
        k = esc_phase - jsu_pkg::PH_U0;
        if (fin) begin
          // \u cut short by the end of the string
          for (int i = 0; i < k; i++) tail[i] = held_chars[i];
          tail[k] = c;
          put_char(jsu_pkg::CH_BSL);
          put_char(jsu_pkg::CH_U);
          replay_tail(tail, k + 1);
        end else begin
          held_chars[k] = c;
          cp_acc = {cp_acc[11:0], hex_nibble(c)};
          esc_phase = esc_phase + 3'd1;
        end
      end
    endcase
    if (fin) begin
      r = '{out_byte: 8'h00, byte_valid: 1'b0, string_done: 1'b1, run_last: 1'b0};
      if (item_results.size() < jsu_pkg::MAX_RES) item_results.push_back(r);
      esc_phase = jsu_pkg::PH_PLAIN;
      cp_acc = '0;
      emitted = 0;
    end
    if (item_results.size() > 0) begin
      r = item_results.pop_back();
      r.run_last = 1'b1;
      item_results.push_back(r);
    end
    foreach (item_results[i]) decoded_q.push_back(item_results[i]);
  endtask

  // ---------------------------------------------------------------------
  // Driver: change inputs on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      // Hold a stalled item; otherwise load the next one or idle.
      if (!in_valid || byte_taken) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict and check
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    jsu_pkg::jsu_out_t want;
    byte_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) limit_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        accepted_count++;
        predict_item(in_data.in_byte, in_data.last_byte);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result: byte=%h valid=%b done=%b last=%b", $time,
                   out_data.out_byte, out_data.byte_valid, out_data.string_done,
                   out_data.run_last);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data !== want) begin
            $display("%0t: mismatch: expected byte=%h valid=%b done=%b last=%b", $time,
                     want.out_byte, want.byte_valid, want.string_done, want.run_last);
            $display("%0t:           actual   byte=%h valid=%b done=%b last=%b", $time,
                     out_data.out_byte, out_data.byte_valid, out_data.string_done,
                     out_data.run_last);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic fin);
    jsu_pkg::jsu_in_t it;
    it.in_byte   = b;
    it.last_byte = fin;
    pending_q.push_back(it);
    queued_count++;
  endtask

  task automatic push_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], close && i == s.len() - 1);
  endtask

  function automatic logic [7:0] hex_digit_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(5))
      0: return jsu_pkg::CH_SLASH;
      1: return jsu_pkg::CH_QUOTE;
      2: return jsu_pkg::CH_BSL;
      3: return jsu_pkg::CH_N;
      4: return jsu_pkg::CH_T;
      default: return jsu_pkg::CH_R;
    endcase
  endfunction

  // Bytes that make a cut-off \u tail interesting to replay.
  function automatic logic [7:0] tail_char();
    case ($urandom_range(3))
      0: return jsu_pkg::CH_BSL;
      1: return escape_letter();
      2: return hex_digit_char($urandom_range(15));
      default: return $urandom_range(255);
    endcase
  endfunction

  // Build one string body, mostly well-formed pieces with random content,
  // then mark its final byte.
  task automatic queue_random_string();
    logic [7:0] body[$];
    logic [7:0] ch;
    logic [15:0] cp;
    int pick;
    int held;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        ch = $urandom_range(255);
        body.push_back(ch == jsu_pkg::CH_BSL ? 8'h41 : ch);
      end else if (pick < 55) begin
        body.push_back(jsu_pkg::CH_BSL);
        body.push_back(escape_letter());
      end else if (pick < 80) begin
        // spread code points over the one, two and three byte encodings
        case ($urandom_range(2))
          0: cp = $urandom_range(16'h007F);
          1: cp = $urandom_range(16'h07FF, 16'h0080);
          default: cp = $urandom_range(16'hFFFF, 16'h0800);
        endcase
        body.push_back(jsu_pkg::CH_BSL);
        body.push_back(jsu_pkg::CH_U);
        for (int d = 3; d >= 0; d--) begin
          ch = hex_digit_char(cp[4 * d +: 4]);
          if ($urandom_range(9) == 0) ch = $urandom_range(255);
          body.push_back(ch);
        end
      end else if (pick < 90) begin
        body.push_back(jsu_pkg::CH_BSL);
        body.push_back($urandom_range(255));
      end else begin
        body.push_back($urandom_range(255));
      end
    end
    // Sometimes break the ending: a \u cut short, or a lone backslash.
    pick = $urandom_range(99);
    if (pick < 15) begin
      held = $urandom_range(2);
      body.push_back(jsu_pkg::CH_BSL);
      body.push_back(jsu_pkg::CH_U);
      repeat (held + 1) body.push_back(tail_char());
    end else if (pick < 25) begin
      body.push_back(jsu_pkg::CH_BSL);
    end
    foreach (body[i]) push_byte(body[i], i == body.size() - 1);
  endtask

  // Quiet point: every item taken, every result seen, and an extra wait
  // for items that produced nothing.
  task automatic wait_idle();
    while (accepted_count != queued_count || decoded_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_limit(input logic [10:0] v);
    @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [10:0] limit_plan [9];
    int seg_start;
    // Extremes of the register, limits of zero and one, tiny limits that
    // cut multibyte characters, and one random setting.
    limit_plan = '{11'd2047, 11'd1024, 11'd0, 11'd1, 11'd2, 11'd5, 11'd9,
                   11'd1023, 11'd64};
    limit_plan[8] = $urandom_range(3, 64);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct  = 13;
    recv_stall_pct = 52;

    // Directed strings at the reset limit:
    // two byte \u with a lower case and a non-hex digit, unknown escape,
    // byte extremes as plain text.
    push_text("\\u00eZ\\q", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    // simple escape, three byte \u, lone trailing backslash
    push_text("\\n\\u20AC\\", 1'b1);
    // \u cut short, a backslash held as a digit and replayed as an escape
    push_text("\\u4\\n", 1'b1);
    wait_idle();

    // Random strings, one limit per segment; idling shifts between the
    // sides and finally stops.
    for (int s = 0; s < 9; s++) begin
      send_idle_pct  = (s < 3) ? 13 : (s < 6) ? 52 : 0;
      recv_stall_pct = (s < 3) ? 52 : (s < 6) ? 13 : 0;
      write_limit(limit_plan[s]);
      seg_start = queued_count;
      while (queued_count - seg_start < 25) queue_random_string();
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("json_string_unescape_utf8_top_tb: PASS");
    end else begin
      $display("json_string_unescape_utf8_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("json_string_unescape_utf8_top_tb: FAIL");
    $finish;
  end

endmodule
